// ----- sv/lxkd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lxkd_pkg
// Shared types, constants and helpers for the lagged XOR keystream decryptor.
// ----------------------------------------------------------------------------
package lxkd_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned RingAw  = 7;
  localparam int unsigned RingLen = 1 << RingAw;

  localparam logic [WordW-1:0]  LcgMul   = 32'd48828125;
  localparam logic [WordW-1:0]  LcgAdd   = 32'd1;
  localparam logic [RingAw-1:0] PadLast  = 7'd126;
  localparam logic [RingAw-1:0] RingLag  = 7'd64;
  localparam logic [RingAw-1:0] PosReset = 7'd127;
  localparam logic [RingAw-1:0] SeedLast = 7'd3;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_READ,
    ST_EXEC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic start_build;
    logic build_step;
    logic rd_en;
    logic exec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic build_last;
    logic out_full;
  } stat_t;

  function automatic logic [WordW-1:0] bswap32(input logic [WordW-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

// ----- sv/lagged_xor_keystream_decrypt_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lagged_xor_keystream_decrypt_top
// Decrypts a word stream by XOR with a lagged-Fibonacci keystream.
// ----------------------------------------------------------------------------
// A word without restart is read from the ring when taken in the idle state
// and combined and registered in the update state; a word with restart first
// rebuilds the pad ring, then reads the ring, then updates. No new word is
// taken until the update, which writes the single-write pad ring, is done.
// Reset clears the controller, the key and the ring position; the pad ring
// itself is not cleared, so the first word after reset must carry restart.
module lagged_xor_keystream_decrypt_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration port. The key register sits at byte address 0.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream.
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,   // [31:0] data_in
  input  wire         s_axis_tuser_i,   // [0] restart
  input  wire         s_axis_tlast_i,   // last_word
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] data_out
  output logic        m_axis_tlast_o    // last_out
);

  logic [31:0]     key_q;
  logic            key_sel;
  lxkd_pkg::cmd_t  cmd;
  lxkd_pkg::stat_t stat;

  // The register index is paddr[2]; only index zero exists, so byte addresses
  // 0 to 3 all reach the key. A write with paddr[2] set changes nothing.
  assign key_sel = ~paddr[2];
  assign pready  = 1'b1;
  assign prdata  = key_sel ? key_q : 32'd0;

  // A new key only matters at the next restart, since the pad is rebuilt
  // from it only then.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (psel && penable && pwrite && key_sel) begin
      key_q <= pwdata;
    end
  end

  // The controller accepts an item only from its idle state; the output
  // register in the datapath lets a finished word wait while the next one
  // is taken.
  lxkd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_restart_i (s_axis_tuser_i),
    .in_ready_o   (s_axis_tready_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  lxkd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .key_i       (key_q),
    .in_data_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ----- sv/lxkd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lxkd_ctrl
// Sequencer for item intake, pad rebuild, ring read and keystream update.
// ----------------------------------------------------------------------------
module lxkd_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_restart_i,
  output logic                 in_ready_o,
  input  lxkd_pkg::stat_t      stat_i,
  output lxkd_pkg::cmd_t       cmd_o
);

  lxkd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lxkd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lxkd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_restart_i ? lxkd_pkg::ST_BUILD : lxkd_pkg::ST_EXEC;
        end
      end
      lxkd_pkg::ST_BUILD: begin
        if (stat_i.build_last) begin
          state_d = lxkd_pkg::ST_READ;
        end
      end
      lxkd_pkg::ST_READ: begin
        state_d = lxkd_pkg::ST_EXEC;
      end
      lxkd_pkg::ST_EXEC: begin
        if (!stat_i.out_full) begin
          state_d = lxkd_pkg::ST_IDLE;
        end
      end
      default: state_d = lxkd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lxkd_pkg::ST_IDLE: begin
        in_ready_o        = 1'b1;
        // Ring reads are issued speculatively so a plain word can go straight to the update state.
        cmd_o.rd_en       = 1'b1;
        cmd_o.load_item   = in_valid_i;
        cmd_o.start_build = in_valid_i & in_restart_i;
      end
      lxkd_pkg::ST_BUILD: begin
        cmd_o.build_step = 1'b1;
      end
      lxkd_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      lxkd_pkg::ST_EXEC: begin
        cmd_o.exec = !stat_i.out_full;
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/lxkd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lxkd_datapath
// Pad ring memory, pad generator, keystream update and output register.
// ----------------------------------------------------------------------------
module lxkd_datapath (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  lxkd_pkg::cmd_t                      cmd_i,
  output lxkd_pkg::stat_t                     stat_o,
  input  wire  [lxkd_pkg::WordW-1:0]          key_i,
  input  wire  [lxkd_pkg::WordW-1:0]          in_data_i,
  input  wire                                 in_last_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [lxkd_pkg::WordW-1:0]          out_data_o,
  output logic                                out_last_o
);

  logic [lxkd_pkg::WordW-1:0]  ring_mem [lxkd_pkg::RingLen];

  logic [lxkd_pkg::RingAw-1:0] pos_q, cnt_q;
  logic [lxkd_pkg::WordW-1:0]  k_q, k_next;
  logic [lxkd_pkg::WordW-1:0]  win_q [4];
  logic [lxkd_pkg::WordW-1:0]  gen_word;
  logic [lxkd_pkg::WordW-1:0]  ra_q, rb_q, ks;
  logic [lxkd_pkg::WordW-1:0]  data_q;
  logic                        last_q;
  logic [lxkd_pkg::RingAw-1:0] addr_a, addr_b, wr_addr;
  logic [lxkd_pkg::WordW-1:0]  wr_data;
  logic                        wr_en;
  logic                        out_valid_q;
  logic [lxkd_pkg::WordW-1:0]  out_data_q;
  logic                        out_last_q;

  // Seed words come from the congruential generator; the fourth is tweaked,
  // the rest follow the shift-XOR recurrence over the last four raw words.
  assign k_next = k_q * lxkd_pkg::LcgMul + lxkd_pkg::LcgAdd;

  always_comb begin
    if (cnt_q < lxkd_pkg::SeedLast) begin
      gen_word = k_next;
    end else if (cnt_q == lxkd_pkg::SeedLast) begin
      gen_word = {k_next[30:0], 1'b0} | {31'd0, win_q[1][31] ^ win_q[3][31]};
    end else begin
      gen_word = {win_q[0][30:0] ^ win_q[2][30:0], 1'b0}
               | {31'd0, win_q[1][31] ^ win_q[3][31]};
    end
  end

  assign addr_a = pos_q + 7'd1;
  assign addr_b = pos_q + 7'd1 + lxkd_pkg::RingLag;
  assign ks     = ra_q ^ rb_q;

  assign wr_en   = cmd_i.build_step | cmd_i.exec;
  assign wr_addr = cmd_i.build_step ? cnt_q : pos_q;
  assign wr_data = cmd_i.build_step ? lxkd_pkg::bswap32(gen_word) : ks;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      ra_q <= ring_mem[addr_a];
      rb_q <= ring_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      data_q <= in_data_i;
      last_q <= in_last_i;
    end
    if (cmd_i.start_build) begin
      k_q <= key_i;
    end else if (cmd_i.build_step) begin
      k_q      <= k_next;
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= gen_word;
    end
    if (cmd_i.exec) begin
      out_data_q <= data_q ^ ks;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= lxkd_pkg::PosReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start_build) begin
        pos_q <= lxkd_pkg::PosReset;
        cnt_q <= '0;
      end else if (cmd_i.build_step) begin
        cnt_q <= cnt_q + 7'd1;
      end else if (cmd_i.exec) begin
        pos_q <= pos_q + 7'd1;
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.build_last = (cnt_q == lxkd_pkg::PadLast);
  assign stat_o.out_full   = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire
